@@ hw/rtl/line_rasterizer_assert.svh @@
// Assertion macros for the line rasterizer checker
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Clocked assertion, disabled while reset is held
`define LR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define LR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/lr_pkg.sv @@
// Shared constants and types for the line rasterizer
package lr_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 24;
    localparam int D_BITS     = COORD_BITS + 3;
    localparam int IN_BITS    = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OCT_SHALLOW_UP,
        OCT_STEEP_UP,
        OCT_STEEP_DOWN,
        OCT_SHALLOW_DOWN
    } oct_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic signed [D_BITS-1:0] d_next;
        logic                     x_inc;
        logic                     y_inc;
        logic                     y_dec;
    } step_t;

endpackage

@@ hw/rtl/line_rasterizer.sv @@
// Line rasterizer: midpoint line walk, one pixel request per cycle unless m_tready stalls
//
// Input channel s_*: one line request per handshake (s_tvalid && s_tready).
//   The block takes a request only while idle; s_tready is low from the
//   accepting edge until the last pixel of that line is in the output register.
// Output channel m_*: one pixel per handshake, m_tlast marks the final pixel.
// Sequence: the endpoints are ordered as they are registered at the accepting
//   edge, then the setup state picks the octant and seeds the decision value,
//   then the run state registers each pixel in the output register.
// Walk: a line of n+1 pixels (n = larger of |dx|, |dy|) uses the shared
//   decision unit once per pixel, after the accept and setup states; a line
//   has at most 64 pixels for 6-bit coordinates.
// A stall on m_tready holds the output register and freezes the pixel walk;
//   the next request may be taken while the last pixel still waits.
// Reset (aresetn low, synchronous) returns the sequencer to idle and clears
//   m_tvalid; any line in progress is dropped.
module line_rasterizer
    import lr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // start_x, start_y, end_x, end_y, line_color (lowest bit up)
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill (lowest bit up)
    output logic [OUT_BITS-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int C = COORD_BITS;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    logic [C-1:0]          x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [C-1:0]          x_reg, y_reg, cnt_reg, n_reg;
    logic signed [D_BITS-1:0] d_reg, tdx_reg, tdy_reg;
    oct_t                  oct_reg;

    logic [C-1:0]          px_reg, py_reg;
    logic [COLOR_BITS-1:0] pcolor_reg;
    logic                  plast_reg;

    logic                  accept;
    logic                  out_free;
    logic                  load_pixel;
    logic                  is_last;

    logic [C-1:0]          in_x0, in_y0, in_x1, in_y1;
    logic                  swap;

    logic [C-1:0]             dx;
    logic signed [C:0]        dy, ndy;
    logic signed [D_BITS-1:0] dxe, dye;
    oct_t                     oct_init;
    logic signed [D_BITS-1:0] d_init;
    logic [C-1:0]             n_init;

    step_t step;

    assign in_x0 = s_tdata[C-1:0];
    assign in_y0 = s_tdata[2*C-1:C];
    assign in_x1 = s_tdata[3*C-1:2*C];
    assign in_y1 = s_tdata[4*C-1:3*C];
    assign swap  = (in_x1 < in_x0);

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = (cnt_reg == n_reg);

    assign dx  = x1_reg - x0_reg;
    assign dy  = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
    assign ndy = -dy;
    assign dxe = $signed({{(D_BITS-C){1'b0}}, dx});
    assign dye = $signed({{(D_BITS-C-1){dy[C]}}, dy});

    always_comb begin
        priority if (!dy[C] && ({1'b0, dx} >= dy)) begin
            oct_init = OCT_SHALLOW_UP;
            d_init   = (dye <<< 1) - dxe;
            n_init   = dx;
        end else if (!dy[C]) begin
            oct_init = OCT_STEEP_UP;
            d_init   = dye - (dxe <<< 1);
            n_init   = dy[C-1:0];
        end else if ({1'b0, dx} <= ndy) begin
            oct_init = OCT_STEEP_DOWN;
            d_init   = dye + (dxe <<< 1);
            n_init   = ndy[C-1:0];
        end else begin
            oct_init = OCT_SHALLOW_DOWN;
            d_init   = (dye <<< 1) + dxe;
            n_init   = dx;
        end
    end

    lr_step_unit u_step (
        .oct  (oct_reg),
        .d    (d_reg),
        .tdx  (tdx_reg),
        .tdy  (tdy_reg),
        .step (step)
    );

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        load_pixel   = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (out_free) begin
                    load_pixel   = 1'b1;
                    m_valid_next = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x0_reg    <= swap ? in_x1 : in_x0;
            y0_reg    <= swap ? in_y1 : in_y0;
            x1_reg    <= swap ? in_x0 : in_x1;
            y1_reg    <= swap ? in_y0 : in_y1;
            color_reg <= s_tdata[4*C+COLOR_BITS-1:4*C];
        end
        if (state_reg == ST_SETUP) begin
            x_reg   <= x0_reg;
            y_reg   <= y0_reg;
            cnt_reg <= '0;
            n_reg   <= n_init;
            oct_reg <= oct_init;
            d_reg   <= d_init;
            tdx_reg <= dxe <<< 1;
            tdy_reg <= dye <<< 1;
        end
        if (load_pixel) begin
            px_reg     <= x_reg;
            py_reg     <= y_reg;
            pcolor_reg <= color_reg;
            plast_reg  <= is_last;
            d_reg      <= step.d_next;
            cnt_reg    <= cnt_reg + C'(1);
            x_reg      <= x_reg + C'(step.x_inc);
            y_reg      <= y_reg + C'(step.y_inc) - C'(step.y_dec);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_BITS'({pcolor_reg, py_reg, px_reg});
    assign m_tlast  = plast_reg;

endmodule

@@ hw/rtl/lr_step_unit.sv @@
// Shared decision update and step selection for one pixel advance
module lr_step_unit
    import lr_pkg::*;
(
    input  oct_t                     oct,
    input  logic signed [D_BITS-1:0] d,
    input  logic signed [D_BITS-1:0] tdx,
    input  logic signed [D_BITS-1:0] tdy,
    output step_t                    step
);

    logic                     minor;
    logic signed [D_BITS-1:0] major_term;
    logic signed [D_BITS-1:0] minor_term;

    always_comb begin
        minor      = 1'b0;
        major_term = '0;
        minor_term = '0;
        step.x_inc = 1'b0;
        step.y_inc = 1'b0;
        step.y_dec = 1'b0;
        unique case (oct)
            OCT_SHALLOW_UP: begin
                minor      = (d > 0);
                major_term = tdy;
                minor_term = -tdx;
                step.x_inc = 1'b1;
                step.y_inc = minor;
            end
            OCT_STEEP_UP: begin
                minor      = (d < 0);
                major_term = -tdx;
                minor_term = tdy;
                step.x_inc = minor;
                step.y_inc = 1'b1;
            end
            OCT_STEEP_DOWN: begin
                minor      = (d > 0);
                major_term = tdx;
                minor_term = tdy;
                step.x_inc = minor;
                step.y_dec = 1'b1;
            end
            OCT_SHALLOW_DOWN: begin
                minor      = (d < 0);
                major_term = tdy;
                minor_term = tdx;
                step.x_inc = 1'b1;
                step.y_dec = minor;
            end
            default: begin
                minor = 1'b0;
            end
        endcase
        step.d_next = d + major_term + (minor ? minor_term : '0);
    end

endmodule

@@ hw/rtl/lr_checker.sv @@
// Port-level assertion checker for the line rasterizer, bound to the top level
`include "line_rasterizer_assert.svh"

module lr_checker
    import lr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata,
    input logic                m_tlast
);

    `LR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled pixel changed")
    `LR_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
    `LR_ASSERT(a_no_accept_mid_line, m_tvalid && !m_tlast |-> !s_tready, "ready during a line")
    `LR_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "pixel valid after reset")

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
